### hw/rtl/tbd_pkg.sv
// Shared types, constants and helpers for the TEA block decrypt unit.
// No dependencies; every other file in hw/rtl refers to this package.
package tbd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned CFG_IDX_W   = $clog2(KEY_WORDS);

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word TEA_DELTA = 32'h9E37_79B9;

    typedef struct packed {
        t_word first;
        t_word second;
    } t_blk;

    typedef struct packed {
        t_word k0;
        t_word k1;
        t_word k2;
        t_word k3;
    } t_key;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2,
        CFG_KEY3 = 2'd3
    } t_cfg_idx;

    // Round sum for round r, counting from the first decrypt round.
    function automatic t_word round_sum(input int unsigned r);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(ROUND_COUNT - r);
        return prod[WORD_W-1:0];
    endfunction

endpackage

### hw/rtl/tbd_cipher_if.sv
// Ciphertext channel: valid/ready handshake carrying one 64-bit block.
// Depends on tbd_pkg for the word type.
interface tbd_cipher_if;
    logic          valid;
    logic          ready;
    tbd_pkg::t_word cipher_first;
    tbd_pkg::t_word cipher_second;

    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

### hw/rtl/tbd_plain_if.sv
// Plaintext channel: valid/ready handshake carrying one decrypted block.
// Depends on tbd_pkg for the word type.
interface tbd_plain_if;
    logic          valid;
    logic          ready;
    tbd_pkg::t_word plain_first;
    tbd_pkg::t_word plain_second;

    modport source (output valid, output plain_first, output plain_second, input ready);
    modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

### hw/rtl/tbd_round.sv
// One TEA decrypt round as two register stages: second word, then first word.
// Depends on tbd_pkg; instantiated ROUND_COUNT times by the top level.
module tbd_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  tbd_pkg::t_blk i_blk,
    input  tbd_pkg::t_word i_sum,
    input  tbd_pkg::t_key i_key,
    output logic          o_vld,
    output tbd_pkg::t_blk o_blk
);

    function automatic tbd_pkg::t_word mix(
        input tbd_pkg::t_word w,
        input tbd_pkg::t_word sum,
        input tbd_pkg::t_word ka,
        input tbd_pkg::t_word kb
    );
        return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
    endfunction

    logic           r_vld_a;
    tbd_pkg::t_blk  r_blk_a;
    tbd_pkg::t_word r_sum_a;
    logic           r_vld_b;
    tbd_pkg::t_blk  r_blk_b;
    tbd_pkg::t_blk  n_blk_a;
    tbd_pkg::t_blk  n_blk_b;

    always_comb begin
        n_blk_a.first  = i_blk.first;
        n_blk_a.second = i_blk.second - mix(i_blk.first, i_sum, i_key.k2, i_key.k3);
        n_blk_b.second = r_blk_a.second;
        n_blk_b.first  = r_blk_a.first - mix(r_blk_a.second, r_sum_a, i_key.k0, i_key.k1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk_a <= n_blk_a;
            r_sum_a <= i_sum;
            r_blk_b <= n_blk_b;
        end
    end

    assign o_vld = r_vld_b;
    assign o_blk = r_blk_b;

endmodule

### hw/rtl/tea_block_decrypt_unit.sv
// TEA block decrypt: 64-bit block, 128-bit key, 32 rounds, fully unrolled.
// An input beat passes two register stages per round, then the output register, before output valid; stalls hold it.
// Throughput: one block per cycle while the skid register is empty; each round is two half-round register stages.
// A one-entry skid register at the output keeps the pipeline moving while a result waits, until the skid fills.
// Reset (synchronous, active low) clears all valid bits and the key registers to zero.
module tea_block_decrypt_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tbd_cipher_if.sink                    i_cipher,
    tbd_plain_if.source                   o_plain,
    input  logic                          i_cfg_we,
    input  logic [tbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tbd_pkg::t_word                i_cfg_data
);

    localparam int unsigned NR = tbd_pkg::ROUND_COUNT;

    tbd_pkg::t_key r_key;

    logic          vld [NR+1];
    tbd_pkg::t_blk blk [NR+1];
    logic          en;

    logic          r_out_vld;
    tbd_pkg::t_blk r_out_blk;
    logic          r_skid_vld;
    tbd_pkg::t_blk r_skid_blk;
    logic          out_fire;
    logic          last_vld;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (tbd_pkg::t_cfg_idx'(i_cfg_index))
                tbd_pkg::CFG_KEY0: r_key.k0 <= i_cfg_data;
                tbd_pkg::CFG_KEY1: r_key.k1 <= i_cfg_data;
                tbd_pkg::CFG_KEY2: r_key.k2 <= i_cfg_data;
                tbd_pkg::CFG_KEY3: r_key.k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline advances unless the skid register is occupied
    assign en             = !r_skid_vld;
    assign i_cipher.ready = en;

    assign vld[0]        = i_cipher.valid;
    assign blk[0].first  = i_cipher.cipher_first;
    assign blk[0].second = i_cipher.cipher_second;

    for (genvar g = 0; g < NR; g++) begin : g_round
        tbd_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[g]),
            .i_blk   (blk[g]),
            .i_sum   (tbd_pkg::round_sum(g)),
            .i_key   (r_key),
            .o_vld   (vld[g+1]),
            .o_blk   (blk[g+1])
        );
    end

    assign out_fire = r_out_vld && o_plain.ready;
    assign last_vld = vld[NR] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_fire || !r_out_vld) begin
            r_out_vld  <= r_skid_vld || last_vld;
            r_skid_vld <= 1'b0;
        end else if (last_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_vld) begin
            r_out_blk <= r_skid_vld ? r_skid_blk : blk[NR];
        end else if (last_vld) begin
            r_skid_blk <= blk[NR];
        end
    end

    assign o_plain.valid        = r_out_vld;
    assign o_plain.plain_first  = r_out_blk.first;
    assign o_plain.plain_second = r_out_blk.second;

endmodule

### hw/rtl/tbd_checker.sv
// Port-level checks for the TEA block decrypt unit, bound to the top level.
// Depends on tbd_pkg and on the port names of tea_block_decrypt_unit.
module tbd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input tbd_pkg::t_word i_out_first,
    input tbd_pkg::t_word i_out_second
);

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_first)
                                        && $stable(i_out_second))
        else $error("output beat changed while stalled");

    // input back-pressure only follows a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without an output stall");

    // reset empties the output and opens the input
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("output valid or input stall right after reset");

    // an empty output never holds back the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output is empty");

endmodule

bind tea_block_decrypt_unit tbd_checker u_tbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_cipher.ready),
    .i_out_valid  (o_plain.valid),
    .i_out_ready  (o_plain.ready),
    .i_out_first  (o_plain.plain_first),
    .i_out_second (o_plain.plain_second)
);
